FILE: src/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the swipe stroke classifier: coordinate and
// register widths, gesture codes, register indexes and the pipeline structs.
// ----------------------------------------------------------------------------
package sws_pkg;

    // Coordinate and configuration widths
    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 12;
    localparam int IDX_BITS   = 2;

    // Compare width: room for either operand plus sign and negation
    localparam int CMP_BITS = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;

    // Configuration reset values
    localparam logic [CFG_BITS-1:0] TRAVEL_RESET = CFG_BITS'(350);
    localparam logic [CFG_BITS-1:0] SPREAD_RESET = CFG_BITS'(40);

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_TRAVEL_THRESHOLD = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_SPREAD_TOLERANCE = IDX_BITS'(1);

    // Direction flag bit positions
    localparam int FLAG_XRISE = 0;
    localparam int FLAG_XFALL = 1;
    localparam int FLAG_YRISE = 2;
    localparam int FLAG_YFALL = 3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0] t_delta;

    // Gesture codes
    typedef enum logic [2:0] {
        GEST_OTHER = 3'd0,
        GEST_X_DEC = 3'd1,
        GEST_X_INC = 3'd2,
        GEST_Y_DEC = 3'd3,
        GEST_Y_INC = 3'd4
    } t_gesture;

    // One touch point as held in the input register
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_point;

    // Stroke summary captured on the last point
    typedef struct packed {
        t_delta dx;        // first_x - last_x
        t_delta dy;        // first_y - last_y
        logic   x_mono;    // x never moved against its overall direction
        logic   y_mono;
        t_coord spread_x;  // max_x - min_x
        t_coord spread_y;
    } t_snap;

endpackage

FILE: src/sws_tracker.sv
// ----------------------------------------------------------------------------
// sws_tracker
// Running stroke state: first and previous point, per-axis extremes and
// rise/fall flags. It registers a stroke summary, marked valid on the last point.
// ----------------------------------------------------------------------------
module sws_tracker
    import sws_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_point i_pt,
    output t_snap  o_snap,
    output logic   o_snap_valid
);

    logic   r_in_stroke;
    t_coord r_first_x, r_first_y, r_prev_x, r_prev_y;
    t_coord r_min_x, r_max_x, r_min_y, r_max_y;
    logic [3:0] r_flags;
    t_snap  r_snap;
    logic   r_snap_valid;

    t_coord n_first_x, n_first_y, n_prev_x, n_prev_y;
    t_coord n_min_x, n_max_x, n_min_y, n_max_y;
    logic [3:0] n_flags;
    t_snap  n_snap;

    // Next stroke state for the point in the input register
    always_comb begin
        if (!r_in_stroke) begin
            n_first_x = i_pt.x;
            n_first_y = i_pt.y;
            n_min_x   = i_pt.x;
            n_max_x   = i_pt.x;
            n_min_y   = i_pt.y;
            n_max_y   = i_pt.y;
            n_flags   = '0;
        end else begin
            n_first_x = r_first_x;
            n_first_y = r_first_y;
            n_min_x   = (i_pt.x < r_min_x) ? i_pt.x : r_min_x;
            n_max_x   = (i_pt.x > r_max_x) ? i_pt.x : r_max_x;
            n_min_y   = (i_pt.y < r_min_y) ? i_pt.y : r_min_y;
            n_max_y   = (i_pt.y > r_max_y) ? i_pt.y : r_max_y;
            n_flags   = r_flags;
            if (i_pt.x > r_prev_x) n_flags[FLAG_XRISE] = 1'b1;
            if (i_pt.x < r_prev_x) n_flags[FLAG_XFALL] = 1'b1;
            if (i_pt.y > r_prev_y) n_flags[FLAG_YRISE] = 1'b1;
            if (i_pt.y < r_prev_y) n_flags[FLAG_YFALL] = 1'b1;
        end
        n_prev_x = i_pt.x;
        n_prev_y = i_pt.y;
    end

    // Stroke summary, taken from the updated state
    always_comb begin
        n_snap.dx = $signed({1'b0, n_first_x}) - $signed({1'b0, i_pt.x});
        n_snap.dy = $signed({1'b0, n_first_y}) - $signed({1'b0, i_pt.y});
        n_snap.x_mono = (n_first_x > i_pt.x) ? !n_flags[FLAG_XRISE] : !n_flags[FLAG_XFALL];
        n_snap.y_mono = (n_first_y > i_pt.y) ? !n_flags[FLAG_YRISE] : !n_flags[FLAG_YFALL];
        n_snap.spread_x = n_max_x - n_min_x;
        n_snap.spread_y = n_max_y - n_min_y;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_stroke  <= 1'b0;
            r_flags      <= '0;
            r_snap_valid <= 1'b0;
        end else if (i_en) begin
            r_snap_valid <= i_valid && i_pt.last;
            if (i_valid) begin
                r_in_stroke <= !i_pt.last;
                r_flags     <= n_flags;
            end
        end
    end

    // Running values and summary
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_valid) begin
                r_first_x <= n_first_x;
                r_first_y <= n_first_y;
                r_prev_x  <= n_prev_x;
                r_prev_y  <= n_prev_y;
                r_min_x   <= n_min_x;
                r_max_x   <= n_max_x;
                r_min_y   <= n_min_y;
                r_max_y   <= n_max_y;
            end
            r_snap <= n_snap;
        end
    end

    assign o_snap       = r_snap;
    assign o_snap_valid = r_snap_valid;

    // A last point always closes the stroke
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid && i_pt.last |=> !r_in_stroke)
        else $error("stroke still open after last point");

    // Extremes stay ordered inside a stroke
    a_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_stroke |-> (r_min_x <= r_max_x) && (r_min_y <= r_max_y))
        else $error("min above max in open stroke");

    // A single-point stroke gives no travel
    a_single_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid && i_pt.last && !r_in_stroke |=>
            (r_snap.dx == '0) && (r_snap.dy == '0))
        else $error("single point stroke shows travel");

endmodule

FILE: src/swipe_stroke_classifier.sv
// ----------------------------------------------------------------------------
// swipe_stroke_classifier
// Classifies a touch stroke, one point per word, into a swipe gesture.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one touch point per word (x, y, last-point mark).
//   A word is taken on a clock edge where i_in_valid is high and o_in_stall
//   is low. Only a point marked last produces an output word: a gesture code
//   (0 other, 1 x decreasing, 2 x increasing, 3 y decreasing, 4 y increasing).
//   Throughput is one point per cycle while o_in_stall is low; the pipeline
//   is input register, stroke tracker stage and result register, and the
//   gesture of a last point is registered in the result register.
//   The configuration port writes travel_threshold (index 0) and
//   spread_tolerance (index 1); other indexes are ignored.
//   Write it only while no stroke is in flight.
//   Reset (synchronous, active low) empties the pipeline, ends any open
//   stroke and restores the threshold to 350 and the tolerance to 40.
//   When the receiver stalls a valid gesture, the whole pipeline holds and
//   o_in_stall rises in the same cycle; nothing is dropped.
// ----------------------------------------------------------------------------
module swipe_stroke_classifier
    import sws_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // point input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    input  logic                i_last_point,
    // gesture output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_gesture,
    // configuration
    input  logic                i_cfg_we,
    input  logic [IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    logic [CFG_BITS-1:0] r_travel, r_spread;
    logic     r_a_valid;
    t_point   r_a;
    logic     r_out_valid;
    t_gesture r_gesture;
    t_gesture n_gesture;

    logic  advance;
    logic  accept;
    t_snap snap;
    logic  snap_valid;

    logic signed [CMP_BITS-1:0] thr_pos, thr_neg, dx_ext, dy_ext;
    logic [CMP_BITS-1:0] tol_ext, sx_ext, sy_ext;

    // Pipeline moves unless a finished gesture is held by the receiver
    assign advance    = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && advance;
    assign o_in_stall = !advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel <= TRAVEL_RESET;
            r_spread <= SPREAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRAVEL_THRESHOLD: r_travel <= i_cfg_data;
                REG_SPREAD_TOLERANCE: r_spread <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a.x    <= i_x_coord;
            r_a.y    <= i_y_coord;
            r_a.last <= i_last_point;
        end
    end

    sws_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_valid      (r_a_valid),
        .i_pt         (r_a),
        .o_snap       (snap),
        .o_snap_valid (snap_valid)
    );

    // Operands extended to a common signed width
    always_comb begin
        thr_pos = $signed({{(CMP_BITS-CFG_BITS){1'b0}}, r_travel});
        thr_neg = -thr_pos;
        dx_ext  = CMP_BITS'(snap.dx);
        dy_ext  = CMP_BITS'(snap.dy);
        tol_ext = {{(CMP_BITS-CFG_BITS){1'b0}}, r_spread};
        sx_ext  = {{(CMP_BITS-COORD_BITS){1'b0}}, snap.spread_x};
        sy_ext  = {{(CMP_BITS-COORD_BITS){1'b0}}, snap.spread_y};
    end

    // Gesture decision: x axis first, then y
    always_comb begin
        if (dx_ext > thr_pos) begin
            n_gesture = (snap.x_mono && (sy_ext <= tol_ext)) ? GEST_X_DEC : GEST_OTHER;
        end else if (dx_ext < thr_neg) begin
            n_gesture = (snap.x_mono && (sy_ext <= tol_ext)) ? GEST_X_INC : GEST_OTHER;
        end else if (dy_ext > thr_pos) begin
            n_gesture = (snap.y_mono && (sx_ext <= tol_ext)) ? GEST_Y_DEC : GEST_OTHER;
        end else if (dy_ext < thr_neg) begin
            n_gesture = (snap.y_mono && (sx_ext <= tol_ext)) ? GEST_Y_INC : GEST_OTHER;
        end else begin
            n_gesture = GEST_OTHER;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_gesture <= n_gesture;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gesture   = r_gesture;

    // A summary reaching the result stage turns into an output word
    a_summary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && snap_valid |=> o_out_valid)
        else $error("stroke summary lost");

    // A held output word blocks new points
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("point taken while output held");

    // A point waiting in the input register survives a stall
    a_hold_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !advance |=> r_a_valid && $stable(r_a))
        else $error("input register changed under stall");

    // Travel within threshold on both axes never yields a swipe
    a_no_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && snap_valid && (dx_ext <= thr_pos) && (dx_ext >= thr_neg) &&
        (dy_ext <= thr_pos) && (dy_ext >= thr_neg) |=> o_gesture == GEST_OTHER)
        else $error("swipe reported without travel");

endmodule
